/* rtl/mds_pkg.sv */
// Package for the mouse delta scaler: widths, codes, reset values and the
// structs that travel between the pipeline stages.
// No dependencies; every other file imports it.
`default_nettype none

package mds_pkg;

  // Field widths of the channels and registers.
  localparam int MDS_CMD_W     = 2;
  localparam int MDS_POS_W     = 16;
  localparam int MDS_SIZE_W    = 11;
  localparam int MDS_SPEED_W   = 5;
  localparam int MDS_CFG_IDX_W = 2;
  localparam int MDS_CFG_DAT_W = 11;
  localparam int MDS_STATUS_W  = 8;
  localparam int MDS_OUT_W     = 8;

  // Datapath widths.
  // Delta is position minus centre: -1023..65535.
  localparam int MDS_DELTA_W = 18;
  // Delta times speed (up to 31): -31713..2031585, below 2^21, signed.
  localparam int MDS_PROD_W  = 24;
  // Magnitude of the product.
  localparam int MDS_MAG_W   = 21;
  // Divide by ten as a multiply by ceil(2^24 / 10), exact for magnitudes below 2^22.
  localparam int MDS_RECIP_SH     = 24;
  localparam int MDS_RECIP_W      = 21;
  localparam int MDS_RECIP_PROD_W = MDS_MAG_W + MDS_RECIP_W;
  localparam logic [MDS_RECIP_W-1:0] MDS_RECIP = MDS_RECIP_W'(1677722);
  // Unsigned quotient of the magnitude, and its signed form.
  localparam int MDS_QUO_W  = MDS_RECIP_PROD_W - MDS_RECIP_SH;
  localparam int MDS_SQUO_W = MDS_QUO_W + 1;
  // Remainder digit 0..9, and signed remainder -9..9.
  localparam int MDS_DIGIT_W = 4;
  localparam int MDS_REM_W   = 5;
  // Small sum of two remainders: -18..18.
  localparam int MDS_TSUM_W  = 6;
  // Quotient after the remainder correction.
  localparam int MDS_FQ_W    = MDS_SQUO_W + 1;

  // Status byte bit positions.
  localparam int MDS_ST_LEFT  = 0;
  localparam int MDS_ST_RIGHT = 1;
  localparam int MDS_ST_XP    = 4;
  localparam int MDS_ST_XN    = 5;
  localparam int MDS_ST_YP    = 6;
  localparam int MDS_ST_YN    = 7;

  // Reset values of the registers and of the pointer.
  localparam logic [MDS_SIZE_W-1:0]  MDS_WIDTH_RST  = MDS_SIZE_W'(768);
  localparam logic [MDS_SIZE_W-1:0]  MDS_HEIGHT_RST = MDS_SIZE_W'(512);
  localparam logic [MDS_SPEED_W-1:0] MDS_SPEED_RST  = MDS_SPEED_W'(10);
  localparam logic [MDS_POS_W-1:0]   MDS_PTR_X_RST  =
    MDS_POS_W'(MDS_WIDTH_RST[MDS_SIZE_W-1:1]);
  localparam logic [MDS_POS_W-1:0]   MDS_PTR_Y_RST  =
    MDS_POS_W'(MDS_HEIGHT_RST[MDS_SIZE_W-1:1]);

  // Input commands.
  typedef enum logic [MDS_CMD_W-1:0] {
    CMD_MOVE   = 2'd0,
    CMD_LEFT   = 2'd1,
    CMD_RIGHT  = 2'd2,
    CMD_SAMPLE = 2'd3
  } mds_cmd_t;

  // Configuration register indexes.
  typedef enum logic [MDS_CFG_IDX_W-1:0] {
    REG_CAPTURE = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2,
    REG_SPEED   = 2'd3
  } mds_reg_t;

  // Current configuration.
  typedef struct packed {
    logic                   capture;
    logic [MDS_SIZE_W-1:0]  width;
    logic [MDS_SIZE_W-1:0]  height;
    logic [MDS_SPEED_W-1:0] speed;
  } mds_cfg_t;

  // Stage 1: scaled deltas of one sample.
  typedef struct packed {
    logic                          capture;
    logic [1:0]                    buttons;
    logic signed [MDS_PROD_W-1:0]  prod_x;
    logic signed [MDS_PROD_W-1:0]  prod_y;
  } mds_s1_t;

  // Stage 2: one axis after the reciprocal multiply.
  typedef struct packed {
    logic                        neg;
    logic [MDS_MAG_W-1:0]        mag;
    logic [MDS_RECIP_PROD_W-1:0] recip;
  } mds_s2_axis_t;

  typedef struct packed {
    logic         capture;
    logic [1:0]   buttons;
    mds_s2_axis_t x;
    mds_s2_axis_t y;
  } mds_s2_t;

  // Stage 3: one axis as a signed quotient and remainder of the product.
  typedef struct packed {
    logic signed [MDS_SQUO_W-1:0] quo;
    logic signed [MDS_REM_W-1:0]  rem;
  } mds_s3_axis_t;

  typedef struct packed {
    logic         capture;
    logic [1:0]   buttons;
    mds_s3_axis_t x;
    mds_s3_axis_t y;
  } mds_s3_t;

  // Final result of one axis.
  typedef struct packed {
    logic signed [MDS_OUT_W-1:0] delta;
    logic                        ovf_pos;
    logic                        ovf_neg;
    logic signed [MDS_REM_W-1:0] rem;
  } mds_axis_res_t;

endpackage

`default_nettype wire

/* rtl/mds_in_if.sv */
// Input channel of the mouse delta scaler: pointer events and sample requests.
// Depends on mds_pkg.
`default_nettype none

interface mds_in_if import mds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MDS_CMD_W-1:0] cmd;
  logic [MDS_POS_W-1:0] pos_x;
  logic [MDS_POS_W-1:0] pos_y;
  logic                 button_pressed;

  modport source (output valid, cmd, pos_x, pos_y, button_pressed, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, button_pressed, output ready);
endinterface

`default_nettype wire

/* rtl/mds_out_if.sv */
// Result channel of the mouse delta scaler: one report per sample request.
// Depends on mds_pkg.
`default_nettype none

interface mds_out_if import mds_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [MDS_STATUS_W-1:0]     status;
  logic signed [MDS_OUT_W-1:0] delta_x;
  logic signed [MDS_OUT_W-1:0] delta_y;

  modport source (output valid, status, delta_x, delta_y, input ready);
  modport sink   (input valid, status, delta_x, delta_y, output ready);
endinterface

`default_nettype wire

/* rtl/mds_cfg_if.sv */
// Configuration write channel of the mouse delta scaler.
// Depends on mds_pkg.
`default_nettype none

interface mds_cfg_if import mds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MDS_CFG_IDX_W-1:0] index;
  logic [MDS_CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/mds_cfg_regs.sv */
// Configuration registers: capture enable, screen size and speed.
// Depends on mds_pkg and mds_cfg_if.
`default_nettype none

module mds_cfg_regs import mds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mds_cfg_if.sink   cfg_ch,
  output mds_cfg_t  cfg
);

  mds_cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register file, written on a configuration transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capture <= 1'b0;
      cfg_r.width   <= MDS_WIDTH_RST;
      cfg_r.height  <= MDS_HEIGHT_RST;
      cfg_r.speed   <= MDS_SPEED_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (mds_reg_t'(cfg_ch.index))
        REG_CAPTURE: cfg_r.capture <= cfg_ch.data[0];
        REG_WIDTH:   cfg_r.width   <= cfg_ch.data[MDS_SIZE_W-1:0];
        REG_HEIGHT:  cfg_r.height  <= cfg_ch.data[MDS_SIZE_W-1:0];
        REG_SPEED:   cfg_r.speed   <= cfg_ch.data[MDS_SPEED_W-1:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/mds_event.sv */
// Front end: pointer and button state, and the first pipeline stage that
// scales the offset from the centre by the speed. Depends on mds_pkg, mds_in_if.
`default_nettype none

module mds_event import mds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  mds_in_if.sink   in_ch,
  input  mds_cfg_t cfg,
  input  logic     s2_en,
  output logic     s1_vld,
  output mds_s1_t  s1
);

  logic [MDS_POS_W-1:0]          ptr_x_r;
  logic [MDS_POS_W-1:0]          ptr_y_r;
  logic [1:0]                    btn_r;
  logic                          s1_vld_r;
  mds_s1_t                       s1_r;
  mds_s1_t                       s1_nxt;
  logic                          s1_en;
  logic                          accept;
  mds_cmd_t                      cmd;
  logic [MDS_POS_W-1:0]          ctr_x;
  logic [MDS_POS_W-1:0]          ctr_y;
  logic signed [MDS_DELTA_W-1:0] dx;
  logic signed [MDS_DELTA_W-1:0] dy;
  logic signed [MDS_PROD_W-1:0]  spd;

  // Stage 1 loads when it is empty or its item moves on.
  assign s1_en       = !s1_vld_r || s2_en;
  assign in_ch.ready = s1_en;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = mds_cmd_t'(in_ch.cmd);

  assign ctr_x = MDS_POS_W'(cfg.width[MDS_SIZE_W-1:1]);
  assign ctr_y = MDS_POS_W'(cfg.height[MDS_SIZE_W-1:1]);

  // Offset from the centre times the speed.
  always_comb begin
    dx  = $signed(MDS_DELTA_W'(ptr_x_r)) - $signed(MDS_DELTA_W'(ctr_x));
    dy  = $signed(MDS_DELTA_W'(ptr_y_r)) - $signed(MDS_DELTA_W'(ctr_y));
    spd = $signed(MDS_PROD_W'(cfg.speed));
    s1_nxt.capture = cfg.capture;
    s1_nxt.buttons = btn_r;
    s1_nxt.prod_x  = MDS_PROD_W'(dx) * spd;
    s1_nxt.prod_y  = MDS_PROD_W'(dy) * spd;
  end

  // Pointer and button state; a live sample returns the pointer to the centre.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_x_r <= MDS_PTR_X_RST;
      ptr_y_r <= MDS_PTR_Y_RST;
      btn_r   <= 2'b00;
    end else if (accept && cfg.capture) begin
      unique case (cmd)
        CMD_MOVE: begin
          ptr_x_r <= in_ch.pos_x;
          ptr_y_r <= in_ch.pos_y;
        end
        CMD_LEFT:   btn_r[MDS_ST_LEFT]  <= in_ch.button_pressed;
        CMD_RIGHT:  btn_r[MDS_ST_RIGHT] <= in_ch.button_pressed;
        CMD_SAMPLE: begin
          ptr_x_r <= ctr_x;
          ptr_y_r <= ctr_y;
        end
        default: btn_r <= btn_r;
      endcase
    end
  end

  // Only sample requests enter the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= accept && (cmd == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_vld = s1_vld_r;
  assign s1     = s1_r;

endmodule

`default_nettype wire

/* rtl/mds_div10.sv */
// Divide-by-ten stages: a reciprocal multiply, then the signed quotient and
// remainder of each scaled delta. Depends on mds_pkg.
`default_nettype none

module mds_div10 import mds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_vld,
  input  mds_s1_t s1,
  input  logic    s4_en,
  output logic    s2_en,
  output logic    s3_vld,
  output mds_s3_t s3
);

  logic    s2_vld_r;
  logic    s3_vld_r;
  mds_s2_t s2_r;
  mds_s2_t s2_nxt;
  mds_s3_t s3_r;
  mds_s3_t s3_nxt;
  logic    s3_en;

  // Magnitude and reciprocal product of one axis.
  function automatic mds_s2_axis_t f_recip(logic signed [MDS_PROD_W-1:0] p);
    mds_s2_axis_t a;
    logic [MDS_PROD_W-1:0] m;
    m       = p[MDS_PROD_W-1] ? MDS_PROD_W'(-p) : MDS_PROD_W'(p);
    a.neg   = p[MDS_PROD_W-1];
    a.mag   = m[MDS_MAG_W-1:0];
    a.recip = MDS_RECIP_PROD_W'(a.mag) * MDS_RECIP_PROD_W'(MDS_RECIP);
    return a;
  endfunction

  // Truncating quotient and remainder, with the sign put back.
  function automatic mds_s3_axis_t f_quo(mds_s2_axis_t a);
    mds_s3_axis_t r;
    logic [MDS_QUO_W-1:0]   q;
    logic [MDS_MAG_W-1:0]   ten_q;
    logic [MDS_MAG_W-1:0]   diff;
    logic [MDS_DIGIT_W-1:0] d;
    q     = a.recip[MDS_RECIP_PROD_W-1:MDS_RECIP_SH];
    ten_q = MDS_MAG_W'({q, 3'b000}) + MDS_MAG_W'({q, 1'b0});
    diff  = a.mag - ten_q;
    d     = diff[MDS_DIGIT_W-1:0];
    r.quo = a.neg ? -$signed(MDS_SQUO_W'(q)) : $signed(MDS_SQUO_W'(q));
    r.rem = a.neg ? -$signed(MDS_REM_W'(d)) : $signed(MDS_REM_W'(d));
    return r;
  endfunction

  // Handshake between stages.
  assign s3_en = !s3_vld_r || s4_en;
  assign s2_en = !s2_vld_r || s3_en;

  always_comb begin
    s2_nxt.capture = s1.capture;
    s2_nxt.buttons = s1.buttons;
    s2_nxt.x       = f_recip(s1.prod_x);
    s2_nxt.y       = f_recip(s1.prod_y);
    s3_nxt.capture = s2_r.capture;
    s3_nxt.buttons = s2_r.buttons;
    s3_nxt.x       = f_quo(s2_r.x);
    s3_nxt.y       = f_quo(s2_r.y);
  end

  // Valid bits of stages 2 and 3.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_vld_r <= s1_vld;
      end
      if (s3_en) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_r <= s2_nxt;
    end
    if (s3_en) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3_vld = s3_vld_r;
  assign s3     = s3_r;

endmodule

`default_nettype wire

/* rtl/mds_accum.sv */
// Last stage: adds the kept remainders, corrects the quotient, clamps, and
// holds the report in the output register. Depends on mds_pkg and mds_out_if.
`default_nettype none

module mds_accum import mds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s3_vld,
  input  mds_s3_t   s3,
  output logic      s4_en,
  mds_out_if.source out_ch
);

  logic                        out_vld_r;
  logic [MDS_STATUS_W-1:0]     status_r;
  logic signed [MDS_OUT_W-1:0] dx_r;
  logic signed [MDS_OUT_W-1:0] dy_r;
  logic signed [MDS_REM_W-1:0] rem_x_r;
  logic signed [MDS_REM_W-1:0] rem_y_r;
  mds_axis_res_t               res_x;
  mds_axis_res_t               res_y;
  logic [MDS_STATUS_W-1:0]     status_nxt;
  logic                        live;

  // One axis: quotient of (remainder + product) / 10, truncated, then clamped.
  function automatic mds_axis_res_t f_axis(mds_s3_axis_t a,
                                           logic signed [MDS_REM_W-1:0] rem);
    mds_axis_res_t r;
    logic signed [MDS_TSUM_W-1:0] t;
    logic signed [MDS_TSUM_W-1:0] u;
    logic signed [MDS_TSUM_W-1:0] rr;
    logic signed [MDS_FQ_W-1:0]   c;
    logic signed [MDS_FQ_W-1:0]   f;
    logic signed [MDS_FQ_W-1:0]   q;
    t = $signed(MDS_TSUM_W'(a.rem)) + $signed(MDS_TSUM_W'(rem));
    // Floor split of the small sum into a carry and a digit 0..9.
    if (t < -MDS_TSUM_W'(10)) begin
      c = -MDS_FQ_W'(2);
      u = t + MDS_TSUM_W'(20);
    end else if (t < MDS_TSUM_W'(0)) begin
      c = -MDS_FQ_W'(1);
      u = t + MDS_TSUM_W'(10);
    end else if (t >= MDS_TSUM_W'(10)) begin
      c = MDS_FQ_W'(1);
      u = t - MDS_TSUM_W'(10);
    end else begin
      c = MDS_FQ_W'(0);
      u = t;
    end
    f = $signed(MDS_FQ_W'(a.quo)) + c;
    // Floor to truncation: a negative sum with a nonzero digit rounds up.
    if (f < MDS_FQ_W'(0) && u != MDS_TSUM_W'(0)) begin
      q  = f + MDS_FQ_W'(1);
      rr = u - MDS_TSUM_W'(10);
    end else begin
      q  = f;
      rr = u;
    end
    r.rem = rr[MDS_REM_W-1:0];
    // Saturate to the report range.
    if (q > MDS_FQ_W'(127)) begin
      r.delta   = MDS_OUT_W'(127);
      r.ovf_pos = 1'b1;
      r.ovf_neg = 1'b0;
    end else if (q < -MDS_FQ_W'(128)) begin
      r.delta   = MDS_OUT_W'(-128);
      r.ovf_pos = 1'b0;
      r.ovf_neg = 1'b1;
    end else begin
      r.delta   = q[MDS_OUT_W-1:0];
      r.ovf_pos = 1'b0;
      r.ovf_neg = 1'b0;
    end
    return r;
  endfunction

  // The output register loads when it is empty or its report is taken.
  assign s4_en = !out_vld_r || out_ch.ready;
  assign live  = s3_vld && s3.capture;

  always_comb begin
    res_x = f_axis(s3.x, rem_x_r);
    res_y = f_axis(s3.y, rem_y_r);
    status_nxt                = '0;
    status_nxt[MDS_ST_LEFT]   = s3.buttons[MDS_ST_LEFT];
    status_nxt[MDS_ST_RIGHT]  = s3.buttons[MDS_ST_RIGHT];
    status_nxt[MDS_ST_XP]     = res_x.ovf_pos;
    status_nxt[MDS_ST_XN]     = res_x.ovf_neg;
    status_nxt[MDS_ST_YP]     = res_y.ovf_pos;
    status_nxt[MDS_ST_YN]     = res_y.ovf_neg;
  end

  // Remainders carried from one live sample to the next.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_x_r   <= '0;
      rem_y_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (s4_en) begin
      out_vld_r <= s3_vld;
      if (live) begin
        rem_x_r <= res_x.rem;
        rem_y_r <= res_y.rem;
      end
    end
  end

  // Report payload; a sample with capture off reports zeros.
  always_ff @(posedge clk) begin
    if (s4_en && s3_vld) begin
      if (s3.capture) begin
        status_r <= status_nxt;
        dx_r     <= res_x.delta;
        dy_r     <= res_y.delta;
      end else begin
        status_r <= '0;
        dx_r     <= '0;
        dy_r     <= '0;
      end
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = status_r;
  assign out_ch.delta_x = dx_r;
  assign out_ch.delta_y = dy_r;

  // The kept remainders stay within one digit of zero.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_x_r >= -MDS_REM_W'(9)) && (rem_x_r <= MDS_REM_W'(9)) &&
    (rem_y_r >= -MDS_REM_W'(9)) && (rem_y_r <= MDS_REM_W'(9)))
    else $error("remainder out of range");

  // A report never flags overflow in both directions on one axis.
  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(status_r[MDS_ST_XP] && status_r[MDS_ST_XN]) &&
                  !(status_r[MDS_ST_YP] && status_r[MDS_ST_YN]))
    else $error("overflow flagged both ways");

  // A positive x overflow flag goes with a delta_x saturated to 127.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r[MDS_ST_XP]) |-> (dx_r == MDS_OUT_W'(127)))
    else $error("x overflow without saturation");

  // While the report waits, the remainders do not move.
  a_rem_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s4_en |=> $stable(rem_x_r) && $stable(rem_y_r))
    else $error("remainder changed during stall");

endmodule

`default_nettype wire

/* rtl/mouse_delta_scaler_top.sv */
// Top level of the mouse delta scaler: connects the configuration registers,
// the event front end, the divide stages and the output stage.
// Depends on mds_pkg, the three channel interfaces and the mds_* modules.
//
// Usage:
//   in_chan carries move events, left and right button events and sample
//   requests. Events change the pointer and button state at the edge where
//   they are transferred and produce no report. Each sample request gives
//   exactly one report on out_chan: the button bits, overflow flags and the
//   two clamped deltas. With capture off, events are dropped and a sample
//   reports zeros.
//   cfg_chan writes one register per transfer and is always ready; write it
//   only while no sample is in flight.
//   A sample's report is built in order: the multiply by speed is registered
//   at the edge of its transfer, then come the reciprocal multiply, the
//   quotient and remainder, and finally the remainder correction and clamp
//   into the output register.
//   Throughput: one item per cycle while out_chan is ready; each of the four
//   stages takes a new item whenever it is empty or its item moves on.
//   When out_chan stalls, the report holds and items behind it fill the
//   empty stages; in_chan drops ready only once all stages are full.
//   Synchronous reset (rst_n low) empties the pipeline, centres the pointer
//   for a 768 by 512 screen, clears buttons and remainders, and restores the
//   register defaults: capture off, speed 10.
`default_nettype none

module mouse_delta_scaler_top import mds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mds_in_if.sink    in_chan,
  mds_out_if.source out_chan,
  mds_cfg_if.sink   cfg_chan
);

  mds_cfg_t cfg;
  logic     s1_vld;
  mds_s1_t  s1;
  logic     s2_en;
  logic     s3_vld;
  mds_s3_t  s3;
  logic     s4_en;

  // Configuration registers.
  mds_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_chan),
    .cfg    (cfg)
  );

  // Event state and speed scaling.
  mds_event u_event (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_chan),
    .cfg    (cfg),
    .s2_en  (s2_en),
    .s1_vld (s1_vld),
    .s1     (s1)
  );

  // Divide by ten.
  mds_div10 u_div10 (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s4_en  (s4_en),
    .s2_en  (s2_en),
    .s3_vld (s3_vld),
    .s3     (s3)
  );

  // Remainder correction, clamp and output register.
  mds_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .s3_vld (s3_vld),
    .s3     (s3),
    .s4_en  (s4_en),
    .out_ch (out_chan)
  );

endmodule

`default_nettype wire
